// File: sv/rcfb_pkg.sv
// ----------------------------------------------------------------------------
// rcfb_pkg
// Types, codes and string helpers shared by the route cache modules.
// ----------------------------------------------------------------------------
package rcfb_pkg;

	localparam int KEY_W    = 64;
	localparam int CODE_W   = 40;
	localparam int BUDGET_W = 6;

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 6'd6;
	localparam logic [7:0]          CHAR_LO_A    = 8'h61;
	localparam logic [7:0]          CHAR_LO_Z    = 8'h7a;
	localparam logic [7:0]          CASE_GAP     = 8'd32;

	// operation codes of an input item
	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_STORE  = 2'd1,
		OP_RELOAD = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [2:0] {
		RS_HIT_FULL   = 3'd0,
		RS_HIT_PART   = 3'd1,
		RS_MISS_GRANT = 3'd2,
		RS_MISS_NOBUD = 3'd3,
		RS_EMPTY      = 3'd4,
		RS_STORED     = 3'd5,
		RS_RELOADED   = 3'd6
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_EMIT
	} fsm_t;

	// one cache slot
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CODE_W-1:0] oi;
		logic [CODE_W-1:0] di;
		logic [CODE_W-1:0] oc;
		logic [CODE_W-1:0] dc;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic reload;
		logic store;
		logic empty;
		logic scan_start;
		logic scan_run;
		logic hit;
		logic miss;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic key_empty;
		logic fill_zero;
		logic rd_hit;
		logic rd_end;
		logic out_free;
	} sts_t;

	// clear every byte after the first zero byte of a callsign
	function automatic logic [KEY_W-1:0] clean_key(input logic [KEY_W-1:0] v);
		logic [KEY_W-1:0] r;
		logic live;
		r    = '0;
		live = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (v[KEY_W-1-8*i -: 8] == 8'h00) live = 1'b0;
			if (live) r[KEY_W-1-8*i -: 8] = v[KEY_W-1-8*i -: 8];
		end
		return r;
	endfunction

	// cut an airport code at its end and fold a..z to upper case
	function automatic logic [CODE_W-1:0] clean_code(input logic [CODE_W-1:0] v);
		logic [CODE_W-1:0] r;
		logic [7:0] b;
		logic live;
		r    = '0;
		live = 1'b1;
		for (int i = 0; i < 5; i++) begin
			b = v[CODE_W-1-8*i -: 8];
			if (b == 8'h00) live = 1'b0;
			if (b >= CHAR_LO_A && b <= CHAR_LO_Z) b = b - CASE_GAP;
			if (live) r[CODE_W-1-8*i -: 8] = b;
		end
		return r;
	endfunction

endpackage

// File: sv/rcfb_ctrl.sv
// ----------------------------------------------------------------------------
// rcfb_ctrl
// Sequencer for the route cache: takes an item, runs it, hands off the result.
// ----------------------------------------------------------------------------
module rcfb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    op,
	output logic          in_stall,
	input  rcfb_pkg::sts_t sts,
	output rcfb_pkg::cmd_t cmd
);
	import rcfb_pkg::*;

	fsm_t state_q, state_d;
	logic op_ok;
	logic take;

	// op 3 is swallowed without a result
	assign op_ok    = (op == OP_LOOKUP) || (op == OP_STORE) || (op == OP_RELOAD);
	assign in_stall = (state_q != S_IDLE);
	assign take     = in_valid && !in_stall && op_ok;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.op == OP_LOOKUP && !sts.key_empty && !sts.fill_zero)
					state_d = S_SCAN;
				else
					state_d = S_EMIT;
			end
			S_SCAN: begin
				if (sts.rd_hit || sts.rd_end) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = take;
			end
			S_EXEC: begin
				priority if (sts.op == OP_RELOAD) begin
					cmd.reload = 1'b1;
				end else if (sts.key_empty) begin
					cmd.empty = 1'b1;
				end else if (sts.op == OP_STORE) begin
					cmd.store = 1'b1;
				end else if (sts.fill_zero) begin
					cmd.miss = 1'b1;
				end else begin
					cmd.scan_start = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				priority if (sts.rd_hit) begin
					cmd.hit = 1'b1;
				end else if (sts.rd_end) begin
					cmd.miss = 1'b1;
				end
			end
			S_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded while output register busy");
	a_take_exec: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_EXEC))
		else $error("accepted item not executed");
	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q != S_EXEC))
		else $error("execute step repeated");
`endif

endmodule

// File: sv/rcfb_dpath.sv
// ----------------------------------------------------------------------------
// rcfb_dpath
// Slot memory, scan pipeline, budget, ring pointer and result registers.
// ----------------------------------------------------------------------------
module rcfb_dpath #(
	parameter int ENTRIES = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rcfb_pkg::cmd_t                    cmd,
	output rcfb_pkg::sts_t                    sts,
	input  logic [1:0]                        op,
	input  logic [rcfb_pkg::KEY_W-1:0]        callsign,
	input  logic [rcfb_pkg::CODE_W-1:0]       new_origin_iata,
	input  logic [rcfb_pkg::CODE_W-1:0]       new_dest_iata,
	input  logic [rcfb_pkg::CODE_W-1:0]       new_origin_icao,
	input  logic [rcfb_pkg::CODE_W-1:0]       new_dest_icao,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcfb_pkg::BUDGET_W-1:0]     cfg_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [rcfb_pkg::CODE_W-1:0]       origin_iata,
	output logic [rcfb_pkg::CODE_W-1:0]       dest_iata,
	output logic [rcfb_pkg::CODE_W-1:0]       origin_icao,
	output logic [rcfb_pkg::CODE_W-1:0]       dest_icao
);
	import rcfb_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	entry_t            mem [ENTRIES];
	entry_t            rd_s1;
	entry_t            in_q;
	op_t               op_q;
	logic [AW-1:0]     wp_q;
	logic [CW-1:0]     fill_q;
	logic [AW-1:0]     addr_q;
	logic              iss_q;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic              last;
	logic              match;
	logic              full;
	logic [BUDGET_W-1:0] budget_q;
	logic [BUDGET_W-1:0] fetch_budget_q;
	status_t           res_status_q;
	logic [CODE_W-1:0] res_oi_q, res_di_q, res_oc_q, res_dc_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [CODE_W-1:0] out_oi_q, out_di_q, out_oc_q, out_dc_q;

	assign cfg_ready = 1'b1;

	// scan compare on the registered slot
	assign last  = (CW'(addr_q) == fill_q - CW'(1));
	assign match = (rd_s1.key == in_q.key);
	assign full  = (rd_s1.oi[CODE_W-1 -: 8] != 8'h00) && (rd_s1.di[CODE_W-1 -: 8] != 8'h00);

	assign sts.op        = op_q;
	assign sts.key_empty = (in_q.key == '0);
	assign sts.fill_zero = (fill_q == '0);
	assign sts.rd_hit    = rd_vld_s1 && match;
	assign sts.rd_end    = rd_vld_s1 && rd_last_s1 && !match;
	assign sts.out_free  = !out_valid_q || !out_stall;

	// capture the cleaned item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op_t'(op);
			in_q.key <= clean_key(callsign);
			in_q.oi  <= clean_code(new_origin_iata);
			in_q.di  <= clean_code(new_dest_iata);
			in_q.oc  <= clean_code(new_origin_icao);
			in_q.dc  <= clean_code(new_dest_icao);
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store) mem[wp_q] <= in_q;
		rd_s1 <= mem[addr_q];
	end

	// ring pointer and fill count; slots below the fill count are valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.store) begin
			wp_q <= (wp_q == AW'(ENTRIES - 1)) ? '0 : wp_q + 1'b1;
			if (fill_q != CW'(ENTRIES)) fill_q <= fill_q + 1'b1;
		end
	end

	// advance the scan address, one slot a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			iss_q      <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			addr_q     <= '0;
			iss_q      <= 1'b1;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else if (cmd.scan_run) begin
			rd_vld_s1  <= iss_q;
			rd_last_s1 <= iss_q && last;
			if (iss_q) begin
				addr_q <= addr_q + 1'b1;
				if (last) iss_q <= 1'b0;
			end
		end
	end

	// fetch budget register and remaining budget
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_budget_q <= BUDGET_RESET;
			budget_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) fetch_budget_q <= cfg_data;
			if (cmd.reload) begin
				budget_q <= fetch_budget_q;
			end else if (cmd.miss && budget_q != '0) begin
				budget_q <= budget_q - 1'b1;
			end
		end
	end

	// build the result
	always_ff @(posedge clk) begin
		priority if (cmd.hit) begin
			res_status_q <= full ? RS_HIT_FULL : RS_HIT_PART;
			res_oi_q     <= rd_s1.oi;
			res_di_q     <= rd_s1.di;
			res_oc_q     <= rd_s1.oc;
			res_dc_q     <= rd_s1.dc;
		end else if (cmd.miss || cmd.reload || cmd.empty || cmd.store) begin
			priority if (cmd.reload)          res_status_q <= RS_RELOADED;
			else if (cmd.empty)               res_status_q <= RS_EMPTY;
			else if (cmd.store)               res_status_q <= RS_STORED;
			else if (budget_q == '0)          res_status_q <= RS_MISS_NOBUD;
			else                              res_status_q <= RS_MISS_GRANT;
			res_oi_q <= '0;
			res_di_q <= '0;
			res_oc_q <= '0;
			res_dc_q <= '0;
		end
	end

	// output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_oi_q     <= res_oi_q;
			out_di_q     <= res_di_q;
			out_oc_q     <= res_oc_q;
			out_dc_q     <= res_dc_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign origin_iata = out_oi_q;
	assign dest_iata   = out_di_q;
	assign origin_icao = out_oc_q;
	assign dest_icao   = out_dc_q;

`ifndef ASSERT_OFF
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(ENTRIES))
		else $error("fill count beyond slot count");
	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != CW'(ENTRIES)) |-> (CW'(wp_q) == fill_q))
		else $error("ring pointer out of step with fill count");
	a_budget_down: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.reload |=> (budget_q <= $past(budget_q)))
		else $error("budget grew without a reload");
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != RS_HIT_FULL && out_status_q != RS_HIT_PART)
		|-> (out_oi_q == '0 && out_di_q == '0 && out_oc_q == '0 && out_dc_q == '0))
		else $error("codes present on a result that is not a hit");
`endif

endmodule

// File: sv/route_cache_with_fetch_budget.sv
// ----------------------------------------------------------------------------
// route_cache_with_fetch_budget
// Fully associative callsign-to-route cache with FIFO replacement and a
// budget of outside fetches granted on a miss.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | op, callsign, new_* codes
//  out     | out_valid / out_stall | status, origin/dest iata/icao codes
//  cfg     | cfg_valid / cfg_ready | cfg_data (fetch budget, 6 bits)
//
//  Reload, store and empty-callsign items skip the scan and go from the execute
//  step to the emit step; a lookup walks the slot memory one slot a cycle
//  through its single read port until a hit or the last filled slot, and skips
//  the walk on an empty cache.
//  One item is worked at a time. Reset clears the fill count, so no clearing
//  pass is needed. A waiting result does not stop the next item being taken.
// ----------------------------------------------------------------------------
module route_cache_with_fetch_budget #(
	parameter int ENTRIES = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        op,
	input  logic [rcfb_pkg::KEY_W-1:0]        callsign,
	input  logic [rcfb_pkg::CODE_W-1:0]       new_origin_iata,
	input  logic [rcfb_pkg::CODE_W-1:0]       new_dest_iata,
	input  logic [rcfb_pkg::CODE_W-1:0]       new_origin_icao,
	input  logic [rcfb_pkg::CODE_W-1:0]       new_dest_icao,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcfb_pkg::BUDGET_W-1:0]     cfg_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [rcfb_pkg::CODE_W-1:0]       origin_iata,
	output logic [rcfb_pkg::CODE_W-1:0]       dest_iata,
	output logic [rcfb_pkg::CODE_W-1:0]       origin_icao,
	output logic [rcfb_pkg::CODE_W-1:0]       dest_icao
);
	import rcfb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	rcfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and result path
	rcfb_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.op              (op),
		.callsign        (callsign),
		.new_origin_iata (new_origin_iata),
		.new_dest_iata   (new_dest_iata),
		.new_origin_icao (new_origin_icao),
		.new_dest_icao   (new_dest_icao),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.origin_iata     (origin_iata),
		.dest_iata       (dest_iata),
		.origin_icao     (origin_icao),
		.dest_icao       (dest_icao)
	);

endmodule
